// ----- hw/rtl/lbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

    // Default widths for coordinates and for the parametric fraction.
    localparam int COORD_BITS_DEF      = 16;
    localparam int PARAM_FRAC_BITS_DEF = 16;

    // Register indexes of the window registers (byte address is 4 times the index).
    typedef enum logic [1:0] {
        REG_X_MIN = 2'd0,
        REG_Y_MIN = 2'd1,
        REG_X_MAX = 2'd2,
        REG_Y_MAX = 2'd3
    } reg_idx_t;

    // Per-edge flags that travel with a ratio out of the divider.
    typedef struct packed {
        logic p_neg;    // edge raises t_enter
        logic p_zero;   // edge is parallel to the segment
        logic par_rej;  // parallel edge with the segment outside
    } edge_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lbc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pipelined ratio unit: r = trunc(q * 2^F / p), one quotient bit per stage.
// Magnitudes of two or more are saturated to 2, which keeps every later compare exact.
module lbc_div #(
    parameter int C = lbc_pkg::COORD_BITS_DEF,
    parameter int F = lbc_pkg::PARAM_FRAC_BITS_DEF
) (
    input  wire                      clk,
    input  wire                      ce,
    input  wire  logic signed [C:0]  p,
    input  wire  logic signed [C:0]  q,
    output logic signed [F+2:0]      r,
    output lbc_pkg::edge_flags_t     flags
);
    import lbc_pkg::*;

    localparam int NS = F + 1;
    localparam int RW = F + 3;

    logic [C-1:0]   den_reg  [0:NS];
    logic [C:0]     rem_reg  [0:NS];
    logic [F:0]     quo_reg  [0:NS];
    logic           neg_reg  [0:NS];
    logic           ovf_reg  [0:NS];
    edge_flags_t    flg_reg  [0:NS];

    logic [C:0]     p_abs;
    logic [C:0]     q_abs;
    logic [RW-1:0]  mag;

    // Operand magnitudes; both fit in C bits.
    assign p_abs = p[C] ? -p : p;
    assign q_abs = q[C] ? -q : q;

    // Entry stage: magnitudes, result sign and the saturation test.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            den_reg[0]        <= p_abs[C-1:0];
            rem_reg[0]        <= {1'b0, q_abs[C-1:0]};
            quo_reg[0]        <= '0;
            neg_reg[0]        <= p[C] ^ q[C];
            ovf_reg[0]        <= ({1'b0, q_abs[C-1:0]} >= {p_abs[C-1:0], 1'b0});
            flg_reg[0].p_neg  <= p[C];
            flg_reg[0].p_zero <= (p == '0);
            flg_reg[0].par_rej <= (p == '0) && q[C];
        end
    end

    // Restoring division, one quotient bit in each stage.
    for (genvar s = 1; s <= NS; s++)
    begin : g_stage
        logic [C:0] trial;
        logic       qbit;

        assign trial = (s == 1) ? rem_reg[s-1] : {rem_reg[s-1][C-1:0], 1'b0};
        assign qbit  = (trial >= {1'b0, den_reg[s-1]});

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                den_reg[s] <= den_reg[s-1];
                rem_reg[s] <= qbit ? (trial - {1'b0, den_reg[s-1]}) : trial;
                quo_reg[s] <= {quo_reg[s-1][F-1:0], qbit};
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
                flg_reg[s] <= flg_reg[s-1];
            end
        end
    end

    // Saturate and apply the sign.
    assign mag   = ovf_reg[NS] ? {2'b01, {(F + 1){1'b0}}} : {2'b00, quo_reg[NS]};
    assign r     = neg_reg[NS] ? -$signed(mag) : $signed(mag);
    assign flags = flg_reg[NS];

endmodule

`default_nettype wire

// ----- hw/rtl/liang_barsky_line_clip.sv -----
// Liang-Barsky line clipper, fully pipelined.
// The pipeline depth is set mostly by the ratio dividers, which retire one quotient
// bit per stage; edge terms, S1, S2, products and the output stage add the rest.
// Throughput: one segment per clock; a stall on the output holds the whole pipeline.
// Reset clears all valid bits and returns the window to the full coordinate range.
`timescale 1ns / 1ps
`default_nettype none

module liang_barsky_line_clip #(
    parameter int COORD_BITS      = lbc_pkg::COORD_BITS_DEF,
    parameter int PARAM_FRAC_BITS = lbc_pkg::PARAM_FRAC_BITS_DEF,
    localparam int DW = ((4 * COORD_BITS + 7) / 8) * 8
) (
    input  wire               clk,
    input  wire               rst_n,
    // Input stream
    input  wire               s_tvalid,
    output logic              s_tready,
    input  wire  [DW-1:0]     s_tdata,   // start_x, start_y, end_x, end_y
    // Output stream
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [DW-1:0]     m_tdata,   // clipped_start_x, clipped_start_y,
                                         // clipped_end_x, clipped_end_y
    output logic              m_tuser,   // visible
    // Configuration port
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [3:0]        paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import lbc_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int F  = PARAM_FRAC_BITS;
    localparam int NS = F + 1;
    localparam int RW = F + 3;
    localparam int PW = C + 1 + RW;
    localparam int SW = C + RW + 3;
    localparam logic signed [RW-1:0] T_ONE = {{(RW - F - 1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic signed [SW-1:0] HALF  = {{(SW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};
    localparam logic [C-1:0] MIN_RST = {1'b1, {(C - 1){1'b0}}};
    localparam logic [C-1:0] MAX_RST = {1'b0, {(C - 1){1'b1}}};

    logic ce;

    // ---------------- Window registers ----------------
    logic signed [C-1:0] x_min_reg, y_min_reg, x_max_reg, y_max_reg;
    logic                cfg_wr;
    reg_idx_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    // A write transaction updates the addressed window edge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= MIN_RST;
            y_min_reg <= MIN_RST;
            x_max_reg <= MAX_RST;
            y_max_reg <= MAX_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_X_MIN: x_min_reg <= pwdata[C-1:0];
                REG_Y_MIN: y_min_reg <= pwdata[C-1:0];
                REG_X_MAX: x_max_reg <= pwdata[C-1:0];
                REG_Y_MAX: y_max_reg <= pwdata[C-1:0];
                default:   x_min_reg <= x_min_reg;
            endcase
        end
    end

    // Read data, sign extended.
    always_comb
    begin
        case (cfg_idx)
            REG_X_MIN: prdata = 32'(x_min_reg);
            REG_Y_MIN: prdata = 32'(y_min_reg);
            REG_X_MAX: prdata = 32'(x_max_reg);
            REG_Y_MAX: prdata = 32'(y_max_reg);
            default:   prdata = '0;
        endcase
    end

    // ---------------- Pipeline control ----------------
    // Every stage advances together when the output register can move.
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // ---------------- Stage A: edge terms ----------------
    logic signed [C-1:0] in_ax, in_ay, in_bx, in_by;
    logic signed [C:0]   in_dx, in_dy;
    logic                va_reg;
    logic signed [C-1:0] ax_a_reg, ay_a_reg;
    logic signed [C:0]   dx_a_reg, dy_a_reg;
    logic signed [C:0]   p_reg [0:3];
    logic signed [C:0]   q_reg [0:3];

    assign in_ax = s_tdata[C-1:0];
    assign in_ay = s_tdata[2*C-1:C];
    assign in_bx = s_tdata[3*C-1:2*C];
    assign in_by = s_tdata[4*C-1:3*C];
    assign in_dx = (C+1)'(in_bx) - (C+1)'(in_ax);
    assign in_dy = (C+1)'(in_by) - (C+1)'(in_ay);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ax_a_reg <= in_ax;
            ay_a_reg <= in_ay;
            dx_a_reg <= in_dx;
            dy_a_reg <= in_dy;
            p_reg[0] <= -in_dx;
            q_reg[0] <= (C+1)'(in_ax) - (C+1)'(x_min_reg);
            p_reg[1] <= in_dx;
            q_reg[1] <= (C+1)'(x_max_reg) - (C+1)'(in_ax);
            p_reg[2] <= -in_dy;
            q_reg[2] <= (C+1)'(in_ay) - (C+1)'(y_min_reg);
            p_reg[3] <= in_dy;
            q_reg[3] <= (C+1)'(y_max_reg) - (C+1)'(in_ay);
        end
    end

    // ---------------- Ratio dividers ----------------
    logic signed [RW-1:0] r_div [0:3];
    edge_flags_t          f_div [0:3];

    for (genvar e = 0; e < 4; e++)
    begin : g_edge
        lbc_div #(
            .C (C),
            .F (F)
        ) u_div (
            .clk   (clk),
            .ce    (ce),
            .p     (p_reg[e]),
            .q     (q_reg[e]),
            .r     (r_div[e]),
            .flags (f_div[e])
        );
    end

    // Side data that runs beside the dividers.
    logic                vd_reg  [0:NS];
    logic signed [C-1:0] axd_reg [0:NS];
    logic signed [C-1:0] ayd_reg [0:NS];
    logic signed [C:0]   dxd_reg [0:NS];
    logic signed [C:0]   dyd_reg [0:NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else if (ce)
        begin
            vd_reg[0] <= va_reg;
            for (int i = 1; i <= NS; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            axd_reg[0] <= ax_a_reg;
            ayd_reg[0] <= ay_a_reg;
            dxd_reg[0] <= dx_a_reg;
            dyd_reg[0] <= dy_a_reg;
            for (int i = 1; i <= NS; i++)
            begin
                axd_reg[i] <= axd_reg[i-1];
                ayd_reg[i] <= ayd_reg[i-1];
                dxd_reg[i] <= dxd_reg[i-1];
                dyd_reg[i] <= dyd_reg[i-1];
            end
        end
    end

    // ---------------- Stage S1: per-axis entry and exit ----------------
    logic signed [RW-1:0] ent_c [0:3];
    logic signed [RW-1:0] ext_c [0:3];
    logic                 v1_reg;
    logic                 rej1_reg;
    logic signed [RW-1:0] ent_x_reg, ent_y_reg, ext_x_reg, ext_y_reg;
    logic signed [C-1:0]  ax1_reg, ay1_reg;
    logic signed [C:0]    dx1_reg, dy1_reg;

    // Entering edges bound t from below, leaving edges from above.
    always_comb
    begin
        for (int e = 0; e < 4; e++)
        begin
            ent_c[e] = (!f_div[e].p_zero && f_div[e].p_neg)  ? r_div[e] : '0;
            ext_c[e] = (!f_div[e].p_zero && !f_div[e].p_neg) ? r_div[e] : T_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ent_x_reg <= (ent_c[0] > ent_c[1]) ? ent_c[0] : ent_c[1];
            ent_y_reg <= (ent_c[2] > ent_c[3]) ? ent_c[2] : ent_c[3];
            ext_x_reg <= (ext_c[0] < ext_c[1]) ? ext_c[0] : ext_c[1];
            ext_y_reg <= (ext_c[2] < ext_c[3]) ? ext_c[2] : ext_c[3];
            rej1_reg  <= f_div[0].par_rej || f_div[1].par_rej ||
                         f_div[2].par_rej || f_div[3].par_rej;
            ax1_reg   <= axd_reg[NS];
            ay1_reg   <= ayd_reg[NS];
            dx1_reg   <= dxd_reg[NS];
            dy1_reg   <= dyd_reg[NS];
        end
    end

    // ---------------- Stage S2: interval and accept ----------------
    logic                 v2_reg;
    logic                 ok2_reg;
    logic signed [RW-1:0] te_next, tx_next;
    logic signed [RW-1:0] te2_reg, tx2_reg;
    logic signed [C-1:0]  ax2_reg, ay2_reg;
    logic signed [C:0]    dx2_reg, dy2_reg;

    assign te_next = (ent_x_reg > ent_y_reg) ? ent_x_reg : ent_y_reg;
    assign tx_next = (ext_x_reg < ext_y_reg) ? ext_x_reg : ext_y_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            te2_reg <= te_next;
            tx2_reg <= tx_next;
            ok2_reg <= !rej1_reg && !(te_next > tx_next);
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
        end
    end

    // ---------------- Stage M: products ----------------
    logic                 vm_reg;
    logic                 okm_reg;
    logic signed [PW-1:0] psx_reg, psy_reg, pex_reg, pey_reg;
    logic signed [C-1:0]  axm_reg, aym_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            psx_reg <= dx2_reg * te2_reg;
            psy_reg <= dy2_reg * te2_reg;
            pex_reg <= dx2_reg * tx2_reg;
            pey_reg <= dy2_reg * tx2_reg;
            okm_reg <= ok2_reg;
            axm_reg <= ax2_reg;
            aym_reg <= ay2_reg;
        end
    end

    // ---------------- Output stage: round half up ----------------
    logic signed [SW-1:0] sum_sx, sum_sy, sum_ex, sum_ey;
    logic signed [SW-1:0] flr_sx, flr_sy, flr_ex, flr_ey;
    logic                 out_valid_reg;
    logic                 vis_reg;
    logic [C-1:0]         osx_reg, osy_reg, oex_reg, oey_reg;

    assign sum_sx = (SW'(axm_reg) <<< F) + SW'(psx_reg) + HALF;
    assign sum_sy = (SW'(aym_reg) <<< F) + SW'(psy_reg) + HALF;
    assign sum_ex = (SW'(axm_reg) <<< F) + SW'(pex_reg) + HALF;
    assign sum_ey = (SW'(aym_reg) <<< F) + SW'(pey_reg) + HALF;
    assign flr_sx = sum_sx >>> F;
    assign flr_sy = sum_sy >>> F;
    assign flr_ex = sum_ex >>> F;
    assign flr_ey = sum_ey >>> F;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            vis_reg <= okm_reg;
            osx_reg <= okm_reg ? flr_sx[C-1:0] : '0;
            osy_reg <= okm_reg ? flr_sy[C-1:0] : '0;
            oex_reg <= okm_reg ? flr_ex[C-1:0] : '0;
            oey_reg <= okm_reg ? flr_ey[C-1:0] : '0;
        end
    end

    // Valid bits of the stages outside the dividers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            vm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            va_reg        <= s_tvalid;
            v1_reg        <= vd_reg[NS];
            v2_reg        <= v1_reg;
            vm_reg        <= v2_reg;
            out_valid_reg <= vm_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = vis_reg;
    assign m_tdata  = DW'({oey_reg, oex_reg, osy_reg, osx_reg});

    // ---------------- Assertions ----------------
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("rejected segment carries nonzero coordinates");

    a_interval: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && ok2_reg) |-> (te2_reg >= 0 && tx2_reg <= T_ONE && te2_reg <= tx2_reg))
        else $error("accepted segment has an invalid parameter interval");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(vm_reg) && $stable(okm_reg) && m_tvalid))
        else $error("pipeline moved during an output stall");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready == (!m_tvalid || m_tready)))
        else $error("input ready does not follow the pipeline advance");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (ce && vm_reg) |=> m_tvalid)
        else $error("item lost at the output stage");

endmodule

`default_nettype wire

// ----- tb/tb_liang_barsky_line_clip.sv -----
`timescale 1ns / 1ps

module tb_liang_barsky_line_clip;
    import lbc_pkg::*;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam int DW = 64;
    localparam int LATENCY = FB + 7;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [CB-1:0] ey;
        logic signed [CB-1:0] ex;
        logic signed [CB-1:0] sy;
        logic signed [CB-1:0] sx;
    } segment_t;

    typedef struct {
        logic        visible;
        logic [DW-1:0] coords;
    } clip_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic m_tuser;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    liang_barsky_line_clip dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Window copy used by the predictor.
    logic signed [CB-1:0] win_x_min = -32768;
    logic signed [CB-1:0] win_y_min = -32768;
    logic signed [CB-1:0] win_x_max = 32767;
    logic signed [CB-1:0] win_y_max = 32767;

    segment_t     pending_segments[$];
    clip_result_t expected_clips[$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  error_count = 0;
    int  quiet_cycles = 0;

    // Floor division by 2^FB.
    function automatic longint floor_frac(longint v);
        longint one;
        one = longint'(1) <<< FB;
        if (v >= 0)
            return v / one;
        return -((-v + one - 1) / one);
    endfunction

    function automatic longint rounded_point(longint a, longint d, longint t);
        longint one;
        one = longint'(1) <<< FB;
        return floor_frac(a * one + d * t + one / 2);
    endfunction

    // Narrow one edge's parametric interval; returns 0 on rejection.
    function automatic bit narrow_edge(longint p, longint q, inout longint t_in,
                                       inout longint t_out);
        longint r;
        if (p == 0)
            return q >= 0;
        r = (q * (longint'(1) <<< FB)) / p;
        if (p < 0)
        begin
            if (r > t_in)
                t_in = r;
        end
        else if (r < t_out)
            t_out = r;
        return 1;
    endfunction

    function automatic clip_result_t clip_segment(segment_t s);
        clip_result_t res;
        longint ax, ay, dx, dy, t_in, t_out;
        bit ok;
        ax = s.sx;
        ay = s.sy;
        dx = longint'(s.ex) - ax;
        dy = longint'(s.ey) - ay;
        t_in = 0;
        t_out = longint'(1) <<< FB;
        ok = narrow_edge(-dx, ax - win_x_min, t_in, t_out);
        ok = narrow_edge(dx, win_x_max - ax, t_in, t_out) && ok;
        ok = narrow_edge(-dy, ay - win_y_min, t_in, t_out) && ok;
        ok = narrow_edge(dy, win_y_max - ay, t_in, t_out) && ok;
        if (t_in > t_out)
            ok = 0;
        res.visible = ok;
        res.coords = '0;
        if (ok)
        begin
            res.coords[15:0]  = CB'(rounded_point(ax, dx, t_in));
            res.coords[31:16] = CB'(rounded_point(ay, dy, t_in));
            res.coords[47:32] = CB'(rounded_point(ax, dx, t_out));
            res.coords[63:48] = CB'(rounded_point(ay, dy, t_out));
        end
        return res;
    endfunction

    // Sample the input handshake at the rising edge for the driver.
    logic s_tready_q = 1'b0;
    always @(posedge clk)
        s_tready_q <= s_tready;

    // Driver: presents queued segments, predicts each accepted transaction.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready_q)
            begin
                expected_clips.push_back(clip_segment(segment_t'(s_tdata)));
                void'(pending_segments.pop_front());
            end
            if (!(s_tvalid && !s_tready_q))
            begin
                if (pending_segments.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_segments[0];
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        clip_result_t exp_r;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready)
            begin
                if (expected_clips.size() == 0)
                begin
                    $error("unexpected result transaction tdata=%h", m_tdata);
                    error_count = error_count + 1;
                end
                else
                begin
                    exp_r = expected_clips.pop_front();
                    if (m_tuser !== exp_r.visible)
                    begin
                        $error("visible: expected %0d actual %0d", exp_r.visible, m_tuser);
                        error_count = error_count + 1;
                    end
                    for (int f = 0; f < 4; f++)
                        if (m_tdata[f*16 +: 16] !== exp_r.coords[f*16 +: 16])
                        begin
                            $error("%s: expected %0d actual %0d",
                                   f == 0 ? "clipped_start_x" : f == 1 ? "clipped_start_y" :
                                   f == 2 ? "clipped_end_x" : "clipped_end_y",
                                   $signed(exp_r.coords[f*16 +: 16]),
                                   $signed(m_tdata[f*16 +: 16]));
                            error_count = error_count + 1;
                        end
                end
            end
            if (quiet_cycles > WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_segments.size() > 0 || s_tvalid || expected_clips.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_window(reg_idx_t idx, logic signed [CB-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_X_MIN: win_x_min = value;
            REG_Y_MIN: win_y_min = value;
            REG_X_MAX: win_x_max = value;
            default:   win_y_max = value;
        endcase
    endtask

    task automatic set_window(int x0, int y0, int x1, int y1);
        write_window(REG_X_MIN, CB'(x0));
        write_window(REG_Y_MIN, CB'(y0));
        write_window(REG_X_MAX, CB'(x1));
        write_window(REG_Y_MAX, CB'(y1));
    endtask

    function automatic logic [CB-1:0] rand_coord(int span);
        int mode;
        mode = $urandom_range(9);
        if (mode == 0)
            return CB'($urandom);
        if (mode == 1)
            return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        return CB'(int'($urandom_range(2 * span)) - span);
    endfunction

    task automatic add_segment(int sx, int sy, int ex, int ey);
        segment_t s;
        s.sx = CB'(sx);
        s.sy = CB'(sy);
        s.ex = CB'(ex);
        s.ey = CB'(ey);
        pending_segments.push_back(s);
    endtask

    task automatic add_random(int count, int span);
        segment_t s;
        for (int i = 0; i < count; i++)
        begin
            s.sx = rand_coord(span);
            s.sy = rand_coord(span);
            if ($urandom_range(15) == 0)
            begin
                s.ex = s.sx;
                s.ey = $urandom_range(1) ? s.sy : rand_coord(span);
            end
            else
            begin
                s.ex = rand_coord(span);
                s.ey = rand_coord(span);
            end
            pending_segments.push_back(s);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: full window extremes, degenerate and parallel segments.
        add_segment(-32768, -32768, 32767, 32767);
        add_segment(32767, -32768, -32768, 32767);
        add_segment(5, 5, 5, 5);
        add_segment(-32768, 0, -32768, 0);
        wait_drained();

        set_window(-100, -50, 100, 50);
        add_segment(-200, 0, 200, 0);
        add_segment(0, -200, 0, 200);
        add_segment(-200, 60, 200, 60);
        add_segment(150, -10, 150, 10);
        add_segment(0, 0, 10, 10);
        add_segment(200, 200, 200, 200);
        add_segment(100, 50, 100, 50);
        add_segment(-300, -300, 300, 300);
        add_segment(-300, 100, 300, -100);
        add_segment(-32768, -32768, 32767, 32767);
        add_segment(32767, 32767, -32768, -32768);
        add_segment(-101, 0, -150, 0);
        add_segment(7, -3, -9, 4);
        add_segment(-200, 200, 200, -201);
        wait_drained();

        // Inverted window rejects everything.
        set_window(10, 10, -10, -10);
        add_segment(0, 0, 5, 5);
        add_segment(-100, -100, 100, 100);
        add_segment(0, 0, 0, 0);

        // Random phases with changing windows and idling patterns.
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            case (ph)
                0: set_window(-32768, -32768, 32767, 32767);
                1: set_window(-1000, -800, 1200, 900);
                2: set_window(32767, -32768, 32767, 32767);
                3: set_window(-20, -20, 20, 20);
                4: set_window(-32768, 0, 0, 32767);
                5: set_window(-5000, -5000, 5000, 5000);
                6: set_window(100, 100, 100, 100);
                default: set_window(-300, -32768, 32767, 250);
            endcase
            add_random(135, 2000);
            add_random(100, 32768);
        end
        wait_drained();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
